[rtl/sdwt_pkg.sv]
// Shared types and constants for the SDRAM delay window training block.
package sdwt_pkg;

    localparam int DELAY_STEPS_DEF = 32;
    localparam int OSC_SAMPLES_DEF = 10;

    localparam int DLY_W  = 5;
    localparam int OSC_W  = 8;
    localparam int SUM_W  = 12;
    localparam int DVD_W  = DLY_W + OSC_W;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    localparam logic [DLY_W-1:0] SAFE_DELAY = 5'd16;

    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_PROBE  = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [1:0] RES_SWEEP   = 2'd0;
    localparam logic [1:0] RES_NOMINAL = 2'd1;
    localparam logic [1:0] RES_COMP    = 2'd2;

    typedef enum logic [1:0] {
        DSEL_NONE = 2'd0,
        DSEL_CMD  = 2'd1,
        DSEL_FB   = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_load;
        div_sel_t div_sel;
        logic     latch_avg;
        logic     write_cmd;
        logic     write_fb;
        logic     emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic probe_last;
        logic batch_last;
        logic phase;
        logic avg_zero;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/sdwt_div.sv]
// Restoring divider, one quotient bit per cycle.
module sdwt_div
    import sdwt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [DVD_W-1:0] dividend,
    input  logic [OSC_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [OSC_W-1:0] rem_reg, rem_next;
    logic [OSC_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [OSC_W:0]   shifted;
    logic [OSC_W+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (load)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[OSC_W+1])
            begin
                rem_next = diff[OSC_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[OSC_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load)
        begin
            dsr_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[rtl/sdwt_datapath.sv]
// Sweep window tracking, oscillator averaging, delay scaling and output register.
module sdwt_datapath
    import sdwt_pkg::*;
#(
    parameter int DELAY_STEPS = DELAY_STEPS_DEF,
    parameter int OSC_SAMPLES = OSC_SAMPLES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic                   s_axis_tvalid,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int STEP_W = $clog2(DELAY_STEPS + 1);
    localparam int CNT_W  = $clog2(OSC_SAMPLES + 1);

    // Reciprocal of the sample count, exact for every 12-bit sum
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + OSC_SAMPLES - 1) / OSC_SAMPLES);

    logic [1:0]       kind;
    logic             which;
    logic             phase;
    logic             pass;
    logic [OSC_W-1:0] count;
    logic             acc;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              target_reg, target_next;
    logic              start_vld_reg, start_vld_next;
    logic [DLY_W-1:0]  start_reg, start_next;
    logic [DLY_W-1:0]  end_reg, end_next;
    logic              prev_reg, prev_next;
    logic              closed_reg, closed_next;
    logic [DLY_W-1:0]  cmd_dly_reg, cmd_dly_next;
    logic [DLY_W-1:0]  fb_dly_reg, fb_dly_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [OSC_W-1:0]  nom_reg, nom_next;
    logic [OSC_W-1:0]  avg_reg, avg_next;
    logic              phase_reg, phase_next;
    logic [1:0]        res_kind_reg, res_kind_next;
    logic              found_reg, found_next;

    logic                   out_vld_reg, out_vld_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_TUSER_W-1:0] out_user_reg, out_user_next;

    logic [DLY_W-1:0] step_dly;
    logic [DLY_W:0]   mid_sum;
    logic [DLY_W-1:0] pick;
    logic [DLY_W-1:0] tgt_val;
    logic             probe_ok;
    logic             probe_last;
    logic [SUM_W-1:0] sum_acc;
    logic [PROD_W-1:0] avg_prod;
    logic [OSC_W-1:0]  avg_calc;

    logic [DVD_W-1:0] div_dividend;
    logic [OSC_W-1:0] div_divisor;
    logic [DLY_W-1:0] mul_dly;
    logic [DVD_W-1:0] div_q;
    logic             div_done;

    assign kind  = s_axis_tuser[1:0];
    assign which = s_axis_tuser[2];
    assign phase = s_axis_tuser[3];
    assign pass  = s_axis_tdata[0];
    assign count = s_axis_tdata[OSC_W:1];
    assign acc   = s_axis_tvalid && cmd.accept;

    assign step_dly   = DLY_W'(step_reg);
    assign probe_ok   = (kind == KIND_PROBE) && (step_reg < STEP_W'(DELAY_STEPS));
    assign probe_last = probe_ok && (step_reg == STEP_W'(DELAY_STEPS - 1));
    assign sum_acc    = sum_reg + SUM_W'(count);
    assign avg_prod   = PROD_W'(sum_acc) * PROD_W'(RECIP);
    assign avg_calc   = avg_prod[RECIP_SH +: OSC_W];

    // Divider operand select; the product is taken into the divider's register
    assign mul_dly = (cmd.div_sel == DSEL_FB) ? fb_dly_reg : cmd_dly_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_CMD, DSEL_FB:
            begin
                div_dividend = DVD_W'(mul_dly) * DVD_W'(nom_reg);
                div_divisor  = avg_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = avg_reg;
            end
        endcase
    end

    sdwt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        step_next      = step_reg;
        target_next    = target_reg;
        start_vld_next = start_vld_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        prev_next      = prev_reg;
        closed_next    = closed_reg;
        cmd_dly_next   = cmd_dly_reg;
        fb_dly_next    = fb_dly_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        nom_next       = nom_reg;
        avg_next       = avg_reg;
        phase_next     = phase_reg;
        res_kind_next  = res_kind_reg;
        found_next     = found_reg;
        mid_sum        = '0;
        pick           = SAFE_DELAY;
        tgt_val        = step_dly;

        if (acc && (kind == KIND_BEGIN))
        begin
            target_next    = which;
            step_next      = '0;
            start_vld_next = 1'b0;
            prev_next      = 1'b0;
            closed_next    = 1'b0;
        end

        if (acc && probe_ok)
        begin
            if (pass)
            begin
                if (!start_vld_reg)
                begin
                    start_vld_next = 1'b1;
                    start_next     = step_dly;
                end
                prev_next = 1'b1;
            end
            else if (prev_reg)
            begin
                end_next    = step_dly;
                closed_next = 1'b1;
                prev_next   = 1'b0;
            end
            step_next = step_reg + 1'b1;

            // Center on the closed window, or on the open one up to the last step
            if (closed_next)
            begin
                mid_sum = {1'b0, start_next} + {1'b0, end_next};
                pick    = mid_sum[DLY_W:1];
            end
            else if (prev_next)
            begin
                mid_sum = {1'b0, start_next} + (DLY_W+1)'(DELAY_STEPS - 1);
                pick    = mid_sum[DLY_W:1];
            end
            if (probe_last)
            begin
                tgt_val       = pick;
                res_kind_next = RES_SWEEP;
                found_next    = closed_next || prev_next;
            end
            if (target_reg)
            begin
                fb_dly_next = tgt_val;
            end
            else
            begin
                cmd_dly_next = tgt_val;
            end
        end

        if (acc && (kind == KIND_SAMPLE))
        begin
            phase_next = phase;
            if (cnt_reg == CNT_W'(OSC_SAMPLES - 1))
            begin
                cnt_next = '0;
                sum_next = '0;
                avg_next = avg_calc;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                sum_next = sum_acc;
            end
        end

        if (cmd.latch_avg)
        begin
            found_next = 1'b0;
            if (!phase_reg)
            begin
                nom_next      = avg_reg;
                res_kind_next = RES_NOMINAL;
            end
            else
            begin
                res_kind_next = RES_COMP;
            end
        end

        if (cmd.write_cmd)
        begin
            cmd_dly_next = div_q[DLY_W-1:0];
        end
        if (cmd.write_fb)
        begin
            fb_dly_next = div_q[DLY_W-1:0];
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        if (cmd.emit)
        begin
            out_vld_next  = 1'b1;
            out_user_next = res_kind_reg;
            out_data_next = '0;
            out_data_next[DLY_W-1:0]         = cmd_dly_reg;
            out_data_next[2*DLY_W-1:DLY_W]   = fb_dly_reg;
            out_data_next[2*DLY_W]           = found_reg;
            out_data_next[2*DLY_W+OSC_W:2*DLY_W+1] =
                (res_kind_reg == RES_SWEEP) ? '0 : avg_reg;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            target_reg    <= 1'b0;
            start_vld_reg <= 1'b0;
            start_reg     <= '0;
            end_reg       <= '0;
            prev_reg      <= 1'b0;
            closed_reg    <= 1'b0;
            cmd_dly_reg   <= SAFE_DELAY;
            fb_dly_reg    <= SAFE_DELAY;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            nom_reg       <= '0;
            phase_reg     <= 1'b0;
            res_kind_reg  <= RES_SWEEP;
            found_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            target_reg    <= target_next;
            start_vld_reg <= start_vld_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            prev_reg      <= prev_next;
            closed_reg    <= closed_next;
            cmd_dly_reg   <= cmd_dly_next;
            fb_dly_reg    <= fb_dly_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            nom_reg       <= nom_next;
            phase_reg     <= phase_next;
            res_kind_reg  <= res_kind_next;
            found_reg     <= found_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign status.probe_last = (kind == KIND_PROBE) && probe_last;
    assign status.batch_last = (kind == KIND_SAMPLE) && (cnt_reg == CNT_W'(OSC_SAMPLES - 1));
    assign status.phase      = phase_reg;
    assign status.avg_zero   = (avg_reg == '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_vld_reg || m_axis_tready;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[rtl/sdwt_ctrl.sv]
// Sequencer for request intake, averaging and delay compensation divides.
module sdwt_ctrl
    import sdwt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_AVG      = 6'b000010,
        S_LOAD_CMD = 6'b000100,
        S_DIV_CMD  = 6'b001000,
        S_DIV_FB   = 6'b010000,
        S_EMIT     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = 1'b1;
                if (s_axis_tvalid && status.probe_last)
                begin
                    state_next = S_EMIT;
                end
                else if (s_axis_tvalid && status.batch_last)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                cmd.latch_avg = 1'b1;
                // Nominal batch or zero current average: report without scaling
                if (!status.phase || status.avg_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_LOAD_CMD;
                end
            end
            S_LOAD_CMD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DSEL_CMD;
                state_next   = S_DIV_CMD;
            end
            S_DIV_CMD:
            begin
                cmd.div_sel = DSEL_FB;
                if (status.div_done)
                begin
                    cmd.write_cmd = 1'b1;
                    cmd.div_load  = 1'b1;
                    state_next    = S_DIV_FB;
                end
            end
            S_DIV_FB:
            begin
                if (status.div_done)
                begin
                    cmd.write_fb = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/sdram_delay_window_training.sv]
// Top level of the SDRAM delay window training block.
// Begin and probe requests are taken in the idle state; the last probe of a sweep moves to the
// emit state, which loads the result register. The last sample of a nominal or zero batch
// passes through the averaging and emit states; the last of a current batch passes through
// averaging, then the command and feedback delay divides, before emit. A held result stalls emit.
// Asynchronous active-low reset: delays return to 16; sweep state, batch count, sum and nominal clear.
module sdram_delay_window_training
    import sdwt_pkg::*;
#(
    parameter int DELAY_STEPS = DELAY_STEPS_DEF,
    parameter int OSC_SAMPLES = OSC_SAMPLES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // probe_pass[0], osc_count[8:1], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0], which_delay[2], osc_phase[3]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cmd_delay_out[4:0], fbclk_delay_out[9:5], window_found[10], osc_average[18:11]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sdwt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .status        (status),
        .cmd           (cmd)
    );

    sdwt_datapath #(
        .DELAY_STEPS (DELAY_STEPS),
        .OSC_SAMPLES (OSC_SAMPLES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.accept;

endmodule
